>>> rtl/rse_pkg.sv
// Shared types and constants for the RPN stack evaluator.
package rse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int MASK_W      = 9;

  typedef enum logic [3:0] {
    OP_PUSH   = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_MOD    = 4'd4,
    OP_DIV    = 4'd5,
    OP_DROP   = 4'd6,
    OP_DUP    = 4'd7,
    OP_DUP2   = 4'd8,
    OP_SWAP   = 4'd9,
    OP_ERROR  = 4'd10,
    OP_BEGIN  = 4'd11,
    OP_COMMIT = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_SKIP    = 3'd1,
    STAT_UNDER   = 3'd2,
    STAT_DIVZERO = 3'd3,
    STAT_BLOCKED = 3'd4,
    STAT_OVER    = 3'd5,
    STAT_ERRTOK  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_DOWN,
    CELL_UP,
    CELL_LOAD,
    CELL_SAVE
  } cell_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUP2,
    ST_POP2,
    ST_MUL,
    ST_DIV
  } state_t;

endpackage

>>> rtl/rse_cell.sv
// One stack cell: a working entry and a committed entry.
module rse_cell (
  input  logic                clk,
  input  rse_pkg::cell_mode_t mode,
  input  logic [63:0]         prev_w,
  input  logic [63:0]         next_w,
  output logic [63:0]         work_w
);

  logic [63:0] work_r;
  logic [63:0] comm_r;

  always_ff @(posedge clk) begin
    unique case (mode)
      rse_pkg::CELL_DOWN: work_r <= prev_w;
      rse_pkg::CELL_UP:   work_r <= next_w;
      rse_pkg::CELL_LOAD: work_r <= comm_r;
      rse_pkg::CELL_SAVE: comm_r <= work_r;
      default: ;
    endcase
  end

  assign work_w = work_r;

endmodule

>>> rtl/rse_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle.
module rse_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  input  logic        want_rem,
  output logic        done,
  output logic [63:0] result
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] quo_r;
  logic [64:0] rem_r;
  logic [63:0] dvs_r;
  logic        neg_q_r;
  logic        neg_r_r;
  logic        rem_sel_r;
  logic        done_r;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {rem_r[63:0], quo_r[63]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r     <= '0;
      quo_r     <= dividend[63] ? (64'd0 - dividend) : dividend;
      dvs_r     <= divisor[63] ? (64'd0 - divisor) : divisor;
      rem_r     <= '0;
      neg_q_r   <= dividend[63] ^ divisor[63];
      neg_r_r   <= dividend[63];
      rem_sel_r <= want_rem;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (!diff[64]) begin
        rem_r <= diff;
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

  assign done   = done_r;
  assign result = rem_sel_r ? (neg_r_r ? (64'd0 - rem_r[63:0]) : rem_r[63:0])
                            : (neg_q_r ? (64'd0 - quo_r) : quo_r);

endmodule

>>> rtl/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: control, arithmetic and the cell row.
// Sequencing: push, add, sub, drop, dup, swap, begin, commit and faults end in ST_IDLE; dup2
//   and a zero divisor add ST_DUP2 or ST_POP2; mul adds ST_MUL (shared 32x32 multiplier,
//   four steps); div, mod add ST_DIV (start, 64 quotient bits, write-back); strobe registered.
// Flow control: busy holds input off until the strobe cycle; the receiver cannot stall.
// Reset (rst_n, synchronous) clears depths, poison, mask and control; stack data undefined.
module rpn_stack_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_operation,
  input  logic signed [63:0] in_operand_value,
  input  logic        in_speculative,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_poisoned,
  output logic [6:0]  out_depth,
  output logic signed [63:0] out_top_value,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  localparam int D  = rse_pkg::STACK_DEPTH;
  localparam int DW = rse_pkg::DEPTH_W;

  rse_pkg::state_t    state_r, state_nxt;
  rse_pkg::op_t       op_r, op_nxt;
  rse_pkg::status_t   status_r, status_nxt;
  rse_pkg::cell_mode_t mode [D];

  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] cdepth_r, cdepth_nxt;
  logic          poison_r, poison_nxt;
  logic [rse_pkg::MASK_W-1:0] mask_r;
  logic          out_valid_r, done_nxt;
  logic [63:0]   a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [63:0]   inject;
  logic [63:0]   work_w [D];
  logic          go_dup2, go_pop2, go_mul, go_div;
  logic          div_go_r;
  logic          div_start, div_done;
  logic [63:0]   div_res;
  logic [31:0]   mul_x, mul_y;
  logic [63:0]   prod;
  logic          accept;
  logic [DW:0]   need, grow;

  assign accept = start && (state_r == rse_pkg::ST_IDLE);
  assign busy   = (state_r != rse_pkg::ST_IDLE);

  // Cell row: cell 0 is the top of the stack.
  for (genvar i = 0; i < D; i++) begin : g_cell
    rse_cell u_cell (
      .clk    (clk),
      .mode   (mode[i]),
      .prev_w ((i == 0) ? inject : work_w[(i == 0) ? 0 : i - 1]),
      .next_w ((i == D - 1) ? 64'd0 : work_w[(i == D - 1) ? i : i + 1]),
      .work_w (work_w[i])
    );
  end

  rse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_r),
    .divisor  (b_r),
    .want_rem (op_r == rse_pkg::OP_MOD),
    .done     (div_done),
    .result   (div_res)
  );

  // Shared multiplier: low x low, then the two cross terms.
  always_comb begin
    unique case (cnt_r)
      2'd1:    begin mul_x = a_r[31:0];  mul_y = b_r[63:32]; end
      2'd2:    begin mul_x = a_r[63:32]; mul_y = b_r[31:0];  end
      default: begin mul_x = a_r[31:0];  mul_y = b_r[31:0];  end
    endcase
  end
  assign prod = mul_x * mul_y;

  // Operand counts for word operations.
  always_comb begin
    need = (DW+1)'(2);
    grow = '0;
    if (in_operation == rse_pkg::OP_DROP || in_operation == rse_pkg::OP_DUP) begin
      need = (DW+1)'(1);
    end
    if (in_operation == rse_pkg::OP_DUP) begin
      grow = (DW+1)'(1);
    end else if (in_operation == rse_pkg::OP_DUP2) begin
      grow = (DW+1)'(2);
    end
  end

  // Datapath and cell commands.
  always_comb begin
    for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_HOLD;
    inject     = '0;
    depth_nxt  = depth_r;
    cdepth_nxt = cdepth_r;
    poison_nxt = poison_r;
    status_nxt = status_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    div_start  = 1'b0;
    go_dup2    = 1'b0;
    go_pop2    = 1'b0;
    go_mul     = 1'b0;
    go_div     = 1'b0;
    unique case (state_r)
      rse_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt     = rse_pkg::op_t'(in_operation);
          status_nxt = rse_pkg::STAT_OK;
          done_nxt   = 1'b1;
          priority if (in_operation == rse_pkg::OP_BEGIN) begin
            for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_LOAD;
            depth_nxt  = cdepth_r;
            poison_nxt = 1'b0;
          end else if (in_operation == rse_pkg::OP_COMMIT) begin
            for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_SAVE;
            cdepth_nxt = depth_r;
          end else if (poison_r) begin
            status_nxt = rse_pkg::STAT_SKIP;
          end else if (in_operation == rse_pkg::OP_PUSH) begin
            if ({1'b0, depth_r} >= (DW+1)'(D)) begin
              status_nxt = rse_pkg::STAT_OVER;
              poison_nxt = 1'b1;
            end else begin
              for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_DOWN;
              inject    = in_operand_value;
              depth_nxt = depth_r + DW'(1);
            end
          end else if (in_operation == rse_pkg::OP_ERROR) begin
            status_nxt = rse_pkg::STAT_ERRTOK;
            poison_nxt = 1'b1;
          end else if (in_operation >= rse_pkg::OP_ADD
                       && in_operation <= rse_pkg::OP_SWAP) begin
            priority if (in_speculative && mask_r[4'(in_operation - 4'd1)]) begin
              status_nxt = rse_pkg::STAT_BLOCKED;
              poison_nxt = 1'b1;
            end else if ({1'b0, depth_r} < need) begin
              status_nxt = rse_pkg::STAT_UNDER;
              poison_nxt = 1'b1;
            end else if ({1'b0, depth_r} + grow > (DW+1)'(D)) begin
              status_nxt = rse_pkg::STAT_OVER;
              poison_nxt = 1'b1;
            end else begin
              unique case (rse_pkg::op_t'(in_operation))
                rse_pkg::OP_DROP: begin
                  for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_UP;
                  depth_nxt = depth_r - DW'(1);
                end
                rse_pkg::OP_DUP: begin
                  for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_DOWN;
                  inject    = work_w[0];
                  depth_nxt = depth_r + DW'(1);
                end
                rse_pkg::OP_DUP2: begin
                  // push the lower one now, the old top on the next cycle
                  for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_DOWN;
                  inject    = work_w[1];
                  depth_nxt = depth_r + DW'(1);
                  done_nxt  = 1'b0;
                  go_dup2   = 1'b1;
                end
                rse_pkg::OP_SWAP: begin
                  mode[0] = rse_pkg::CELL_UP;
                  mode[1] = rse_pkg::CELL_DOWN;
                end
                rse_pkg::OP_ADD, rse_pkg::OP_SUB: begin
                  for (int i = 1; i < D; i++) mode[i] = rse_pkg::CELL_UP;
                  mode[0]   = rse_pkg::CELL_DOWN;
                  inject    = (in_operation == rse_pkg::OP_ADD) ?
                              work_w[1] + work_w[0] : work_w[1] - work_w[0];
                  depth_nxt = depth_r - DW'(1);
                end
                rse_pkg::OP_MUL: begin
                  a_nxt    = work_w[1];
                  b_nxt    = work_w[0];
                  cnt_nxt  = 2'd0;
                  done_nxt = 1'b0;
                  go_mul   = 1'b1;
                end
                default: begin
                  // mod and div
                  done_nxt = 1'b0;
                  if (work_w[0] == 64'd0) begin
                    for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_UP;
                    depth_nxt  = depth_r - DW'(1);
                    status_nxt = rse_pkg::STAT_DIVZERO;
                    poison_nxt = 1'b1;
                    go_pop2    = 1'b1;
                  end else begin
                    a_nxt  = work_w[1];
                    b_nxt  = work_w[0];
                    go_div = 1'b1;
                  end
                end
              endcase
            end
          end
        end
      end
      rse_pkg::ST_DUP2: begin
        for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_DOWN;
        inject    = work_w[1];
        depth_nxt = depth_r + DW'(1);
        done_nxt  = 1'b1;
      end
      rse_pkg::ST_POP2: begin
        for (int i = 0; i < D; i++) mode[i] = rse_pkg::CELL_UP;
        depth_nxt = depth_r - DW'(1);
        done_nxt  = 1'b1;
      end
      rse_pkg::ST_MUL: begin
        cnt_nxt = cnt_r + 2'd1;
        unique case (cnt_r)
          2'd0: acc_nxt = prod;
          2'd1, 2'd2: acc_nxt = acc_r + {prod[31:0], 32'd0};
          default: begin
            for (int i = 1; i < D; i++) mode[i] = rse_pkg::CELL_UP;
            mode[0]   = rse_pkg::CELL_DOWN;
            inject    = acc_r;
            depth_nxt = depth_r - DW'(1);
            done_nxt  = 1'b1;
          end
        endcase
      end
      rse_pkg::ST_DIV: begin
        if (div_done) begin
          for (int i = 1; i < D; i++) mode[i] = rse_pkg::CELL_UP;
          mode[0]   = rse_pkg::CELL_DOWN;
          inject    = div_res;
          depth_nxt = depth_r - DW'(1);
          done_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
    // kick the divider on the cycle after the operands are latched
    div_start = div_go_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rse_pkg::ST_IDLE: begin
        priority if (go_dup2) state_nxt = rse_pkg::ST_DUP2;
        else if (go_pop2)     state_nxt = rse_pkg::ST_POP2;
        else if (go_mul)      state_nxt = rse_pkg::ST_MUL;
        else if (go_div)      state_nxt = rse_pkg::ST_DIV;
        else                  state_nxt = rse_pkg::ST_IDLE;
      end
      rse_pkg::ST_DUP2, rse_pkg::ST_POP2: state_nxt = rse_pkg::ST_IDLE;
      rse_pkg::ST_MUL: if (cnt_r == 2'd3) state_nxt = rse_pkg::ST_IDLE;
      rse_pkg::ST_DIV: if (div_done) state_nxt = rse_pkg::ST_IDLE;
      default: state_nxt = rse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rse_pkg::ST_IDLE;
      depth_r     <= '0;
      cdepth_r    <= '0;
      poison_r    <= 1'b0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      status_r    <= rse_pkg::STAT_OK;
      div_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      cdepth_r    <= cdepth_nxt;
      poison_r    <= poison_nxt;
      out_valid_r <= done_nxt;
      status_r    <= status_nxt;
      div_go_r    <= go_div;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_poisoned  = poison_r;
  assign out_depth     = 7'(depth_r);
  assign out_top_value = (depth_r != '0) ? work_w[0] : 64'sd0;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == rse_pkg::OP_BEGIN) |=> (out_valid && !out_poisoned))
    else $error("begin did not clear poison");

  a_fault_poisons: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rse_pkg::STAT_OK && out_status != rse_pkg::STAT_SKIP)
      |-> out_poisoned)
    else $error("fault without poison");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, depth_r} <= (DW+1)'(D)))
    else $error("depth beyond stack");

endmodule
